// ===== hdl/pzarg_pkg.sv =====
// ----------------------------------------------------------------------------
// Activation rate guard package
// Shared widths, reset values, register indexes, control codes and the
// flag group that the bit-serial comparators report.
// ----------------------------------------------------------------------------
package pzarg_pkg;

  localparam int ZONES_DEF = 8;
  localparam int ZONE_ID_W = 4;
  localparam int TIME_W    = 32;
  localparam int CNT_W     = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [TIME_W-1:0] MIN_INTERVAL_RST = TIME_W'(600000);
  localparam logic [CNT_W-1:0]  MAX_PER_WIN_RST  = CNT_W'(6);
  localparam logic [TIME_W-1:0] COOLDOWN_RST     = TIME_W'(3600000);
  localparam logic [TIME_W-1:0] WINDOW_RST       = TIME_W'(3600000);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_INTERVAL = 2'd0,
    CFG_MAX_PER_WIN  = 2'd1,
    CFG_COOLDOWN     = 2'd2,
    CFG_WINDOW       = 2'd3
  } cfg_idx_t;

  // Item opcodes.
  typedef enum logic {
    OP_CHECK = 1'b0,
    OP_CLEAR = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_FINISH
  } state_t;

  // Result of one serial pass: difference above, below threshold, and
  // whether the subtracted stored time had any bit set.
  typedef struct packed {
    logic gt;
    logic lt;
    logic nz;
  } cmp_flags_t;

endpackage

// ===== hdl/pzarg_serial_cmp.sv =====
// ----------------------------------------------------------------------------
// Bit-serial wrapped difference compare
// Forms (now - stored) one bit a cycle while step is high, LSB first, and
// compares the difference against a threshold streamed in alongside it.
// ----------------------------------------------------------------------------
module pzarg_serial_cmp (
  input  logic                  clk,
  input  logic                  start,
  input  logic                  step,
  input  logic                  now_bit,
  input  logic                  sub_bit,
  input  logic                  thr_bit,
  output pzarg_pkg::cmp_flags_t flags
);
  import pzarg_pkg::*;

  logic borrow;
  logic diff_bit;

  assign diff_bit = now_bit ^ sub_bit ^ borrow;

  // The highest differing bit decides the compare, so a later bit overrides.
  always_ff @(posedge clk) begin
    if (start) begin
      borrow <= 1'b0;
      flags  <= '0;
    end else if (step) begin
      borrow   <= (~now_bit & sub_bit) | (~(now_bit ^ sub_bit) & borrow);
      flags.nz <= flags.nz | sub_bit;
      if (diff_bit != thr_bit) begin
        flags.gt <= diff_bit;
        flags.lt <= thr_bit;
      end
    end
  end

endmodule

// ===== hdl/per_zone_activation_rate_guard_core.sv =====
// ----------------------------------------------------------------------------
// Per-zone activation rate guard
// Fixed-window rate limiter with minimum grant spacing and alert cooldown.
// ----------------------------------------------------------------------------
// A check item runs a 32-bit serial pass through the three comparators and
// then a decision step that loads the output register; clear and invalid-zone
// items go straight to the decision. The decision waits while the output
// register holds an unaccepted result. The input takes no new item until the
// decision has loaded the output register.
// Reset: rst (synchronous) restores the register defaults and empties all zones.
module per_zone_activation_rate_guard_core #(
  parameter int ZONES = pzarg_pkg::ZONES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // Input item.
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [39:0]                      s_tdata,  // zone_id[3:0], now_ms[35:4], zero pad
  input  logic [0:0]                       s_tuser,  // opcode[0]
  // Result item.
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [15:0]                      m_tdata,  // granted[0], zone_invalid[1],
                                                     // too_soon[2], alert[3],
                                                     // window_count[11:4], zero pad
  // Configuration writes.
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pzarg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pzarg_pkg::TIME_W-1:0]     cfg_data
);
  import pzarg_pkg::*;

  localparam int ZI_W  = (ZONES > 1) ? $clog2(ZONES) : 1;
  localparam int BIT_W = $clog2(TIME_W);
  localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(TIME_W - 1);
  localparam logic [CNT_W-1:0] CNT_MAX  = {CNT_W{1'b1}};

  // Configuration registers.
  logic [TIME_W-1:0] min_interval;
  logic [CNT_W-1:0]  max_per_win;
  logic [TIME_W-1:0] cooldown;
  logic [TIME_W-1:0] window_len;

  // Zone state. An empty zone reads as all zeros, so a clear only drops the
  // zone's occupied bit.
  logic [ZONES-1:0]  zone_used;
  logic [TIME_W-1:0] ws_mem  [ZONES];
  logic [CNT_W-1:0]  rc_mem  [ZONES];
  logic [TIME_W-1:0] lgt_mem [ZONES];
  logic [TIME_W-1:0] lat_mem [ZONES];

  state_t state, state_next;

  // Item captured on acceptance.
  logic [ZI_W-1:0]      zidx;
  logic                 op_clear;
  logic                 op_invalid;
  logic [BIT_W-1:0]     bit_cnt;
  logic [CNT_W-1:0]     rc_q;

  // Serial shift lines: the current time and the stored zone times rotate so
  // that they are whole again at the end for the write-back; the thresholds
  // simply drain one bit a cycle while shifting.
  logic [TIME_W-1:0] now_sh;
  logic [TIME_W-1:0] ws_sh, lgt_sh, lat_sh;
  logic [TIME_W-1:0] win_sh, min_sh, cd_sh;

  cmp_flags_t win_flags, grant_flags, alert_flags;

  logic [15:0] out_data;

  // Accept path decode.
  logic [ZONE_ID_W-1:0] in_zone;
  logic [ZONE_ID_W-1:0] in_zone_m1;
  logic                 in_invalid;
  logic [ZI_W-1:0]      in_zidx;
  logic                 accept;
  logic                 step;
  logic                 finish;
  logic                 out_free;

  assign in_zone    = s_tdata[ZONE_ID_W-1:0];
  assign in_zone_m1 = in_zone - ZONE_ID_W'(1);
  assign in_zidx    = in_zone_m1[ZI_W-1:0];
  assign in_invalid = (in_zone == '0) || (in_zone > ZONE_ID_W'(ZONES));
  assign out_free   = !m_tvalid || m_tready;
  assign cfg_ready  = !rst;

  // Sequencer: next state and strobes.
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    accept     = 1'b0;
    step       = 1'b0;
    finish     = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = !rst;
        accept   = s_tvalid && !rst;
        if (accept) begin
          if (in_invalid || s_tuser[0] == OP_CLEAR) begin
            state_next = ST_FINISH;
          end else begin
            state_next = ST_SHIFT;
          end
        end
      end
      ST_SHIFT: begin
        step = 1'b1;
        if (bit_cnt == LAST_BIT) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          finish     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Three comparisons share one pass: window expiry, grant spacing and alert
  // cooldown. None of them depends on what the others will write back.
  pzarg_serial_cmp u_win_cmp (
    .clk     (clk),
    .start   (accept),
    .step    (step),
    .now_bit (now_sh[0]),
    .sub_bit (ws_sh[0]),
    .thr_bit (win_sh[0]),
    .flags   (win_flags)
  );

  pzarg_serial_cmp u_grant_cmp (
    .clk     (clk),
    .start   (accept),
    .step    (step),
    .now_bit (now_sh[0]),
    .sub_bit (lgt_sh[0]),
    .thr_bit (min_sh[0]),
    .flags   (grant_flags)
  );

  pzarg_serial_cmp u_alert_cmp (
    .clk     (clk),
    .start   (accept),
    .step    (step),
    .now_bit (now_sh[0]),
    .sub_bit (lat_sh[0]),
    .thr_bit (cd_sh[0]),
    .flags   (alert_flags)
  );

  // Item capture and serial shifting. The zone read happens at acceptance,
  // from the index of the incoming item.
  always_ff @(posedge clk) begin
    if (accept) begin
      zidx       <= in_zidx;
      op_clear   <= (s_tuser[0] == OP_CLEAR);
      op_invalid <= in_invalid;
      bit_cnt    <= '0;
      now_sh     <= s_tdata[ZONE_ID_W +: TIME_W];
      ws_sh      <= zone_used[in_zidx] ? ws_mem[in_zidx]  : '0;
      rc_q       <= zone_used[in_zidx] ? rc_mem[in_zidx]  : '0;
      lgt_sh     <= zone_used[in_zidx] ? lgt_mem[in_zidx] : '0;
      lat_sh     <= zone_used[in_zidx] ? lat_mem[in_zidx] : '0;
      win_sh     <= window_len;
      min_sh     <= min_interval;
      cd_sh      <= cooldown;
    end else if (step) begin
      bit_cnt <= bit_cnt + BIT_W'(1);
      now_sh  <= {now_sh[0], now_sh[TIME_W-1:1]};
      ws_sh   <= {ws_sh[0], ws_sh[TIME_W-1:1]};
      lgt_sh  <= {lgt_sh[0], lgt_sh[TIME_W-1:1]};
      lat_sh  <= {lat_sh[0], lat_sh[TIME_W-1:1]};
      win_sh  <= win_sh >> 1;
      min_sh  <= min_sh >> 1;
      cd_sh   <= cd_sh  >> 1;
    end
  end

  // Decision for a check item.
  logic [CNT_W-1:0] cnt_base, cnt_new;
  logic             too_soon, over_limit, do_alert, granted;

  always_comb begin
    cnt_base   = win_flags.gt ? '0 : rc_q;
    cnt_new    = (cnt_base == CNT_MAX) ? cnt_base : cnt_base + CNT_W'(1);
    // A stored grant or alert time of zero means there was none.
    too_soon   = grant_flags.nz && grant_flags.lt;
    over_limit = (cnt_new >= max_per_win);
    do_alert   = over_limit && !(alert_flags.nz && alert_flags.lt);
    granted    = !too_soon && !over_limit;
  end

  // Zone write-back and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      zone_used <= '0;
    end else if (finish && !op_invalid) begin
      zone_used[zidx] <= !op_clear;
    end
  end

  always_ff @(posedge clk) begin
    if (finish && !op_invalid && !op_clear) begin
      ws_mem[zidx]  <= win_flags.gt ? now_sh : ws_sh;
      rc_mem[zidx]  <= cnt_new;
      lgt_mem[zidx] <= too_soon ? lgt_sh : now_sh;
      lat_mem[zidx] <= do_alert ? now_sh : lat_sh;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      if (op_invalid) begin
        out_data <= 16'h0002;
      end else if (op_clear) begin
        out_data <= '0;
      end else begin
        out_data <= {4'b0000, cnt_new, do_alert, too_soon, 1'b0, granted};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = out_data;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_interval <= MIN_INTERVAL_RST;
      max_per_win  <= MAX_PER_WIN_RST;
      cooldown     <= COOLDOWN_RST;
      window_len   <= WINDOW_RST;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MIN_INTERVAL: min_interval <= cfg_data;
        CFG_MAX_PER_WIN:  max_per_win  <= cfg_data[CNT_W-1:0];
        CFG_COOLDOWN:     cooldown     <= cfg_data;
        CFG_WINDOW:       window_len   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule
